### hw/rtl/opr_pkg.sv
package opr_pkg;

  localparam int unsigned PATTERN_W        = 64;
  localparam int unsigned RANK_W           = 61;
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned LANES            = 64;
  localparam int unsigned BYTES            = LANES / 8;
  localparam int unsigned MAX_ORBITALS_DEF = 64;
  localparam int unsigned OUT_DATA_W       = ((RANK_W + 7) / 8) * 8;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [LANES:0][RANK_W-1:0] binom_row_t;

  typedef enum logic [0:0] {
    REG_ORBITAL_COUNT = 1'b0,
    REG_SET_BIT_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } pipe_en_t;

  function automatic binom_row_t binom_row(input int unsigned row);
    logic [LANES:0][63:0] cur;
    binom_row_t           res;
    cur = '0;
    cur[0] = 64'd1;
    for (int unsigned n = 1; n <= row; n++) begin
      for (int unsigned r = n; r >= 1; r--) begin
        cur[r] = cur[r] + cur[r-1];
      end
    end
    for (int unsigned r = 0; r <= LANES; r++) begin
      res[r] = cur[r][RANK_W-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/occupation_pattern_ranker.sv
// Channel  Direction  tdata                               tuser
// in_      slave      [63:0] pattern                      -
// out_     master     [60:0] rank, [63:61] zero           [0] valid_res
// cfg_     write      cfg_index selects register, cfg_wdata[6:0]
//
// One request per cycle while out_tready is high.
// The rate is set by the seven-stage pipeline: prefix count, binomial ROM, adder tree.
// rst_n is synchronous, active low; it clears the stage valids and both registers.
// Each stage takes a new request whenever it is empty or its successor moves,
// so bubbles fill while out_tready is low; in_tready drops only when all stages hold data.
module occupation_pattern_ranker #(
  parameter int unsigned MAX_ORBITALS = opr_pkg::MAX_ORBITALS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [opr_pkg::PATTERN_W-1:0]  in_tdata,   // [63:0] pattern
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [opr_pkg::OUT_DATA_W-1:0] out_tdata,  // [60:0] rank, rest zero
  output logic                           out_tuser,  // [0] valid_res
  input  logic                           cfg_we,
  input  opr_pkg::cfg_reg_t              cfg_index,
  input  logic [opr_pkg::CNT_W-1:0]      cfg_wdata
);
  import opr_pkg::*;

  localparam int unsigned STAGES = 7;

  logic [STAGES-1:0]    v_r, v_nxt, adv;
  pipe_en_t             en;
  logic [PATTERN_W-1:0] pattern_r;
  cnt_t                 orbital_count_r, set_bit_count_r;
  logic [PATTERN_W-1:0] bits2;
  cnt_t                 cnt2 [LANES];
  logic                 ok2, ok3, ok5;
  rank_t                terms3 [LANES];
  rank_t                partial5 [LANES/16];
  rank_t                rank_nxt, rank_r;
  logic                 valid_res_r;

  always_comb begin
    adv[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    v_nxt[0] = adv[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  assign en = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};

  always_comb begin
    rank_nxt = '0;
    for (int i = 0; i < LANES / 16; i++) begin
      rank_nxt = rank_nxt + partial5[i];
    end
    if (!ok5) begin
      rank_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r             <= '0;
      orbital_count_r <= '0;
      set_bit_count_r <= '0;
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORBITAL_COUNT: orbital_count_r <= cfg_wdata;
          REG_SET_BIT_COUNT: set_bit_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (adv[0]) begin
      pattern_r <= in_tdata;
    end
    if (en.s6) begin
      rank_r      <= rank_nxt;
      valid_res_r <= ok5;
    end
  end

  opr_count #(.MAX_ORBITALS(MAX_ORBITALS)) u_count (
    .clk           (clk),
    .en            (en),
    .pattern       (pattern_r),
    .orbital_count (orbital_count_r),
    .set_bit_count (set_bit_count_r),
    .bits          (bits2),
    .cnt           (cnt2),
    .ok            (ok2)
  );

  opr_terms #(.MAX_ORBITALS(MAX_ORBITALS)) u_terms (
    .clk   (clk),
    .en    (en),
    .bits  (bits2),
    .cnt   (cnt2),
    .ok_in (ok2),
    .terms (terms3),
    .ok    (ok3)
  );

  opr_adder u_adder (
    .clk     (clk),
    .en      (en),
    .terms   (terms3),
    .ok_in   (ok3),
    .partial (partial5),
    .ok      (ok5)
  );

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[STAGES-1];
  assign out_tdata  = {{(OUT_DATA_W - RANK_W){1'b0}}, rank_r};
  assign out_tuser  = valid_res_r;

  a_invalid_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> rank_r == '0)
    else $error("rank not zero for invalid pattern");

  a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted request lost at input stage");

  a_ready_with_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_tready)
    else $error("input stalled while pipeline has a free stage");

  a_output_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES-2] && !out_tvalid |=> out_tvalid)
    else $error("result not moved into empty output stage");

endmodule

### hw/rtl/opr_count.sv
module opr_count #(
  parameter int unsigned MAX_ORBITALS = opr_pkg::MAX_ORBITALS_DEF
) (
  input  logic                           clk,
  input  opr_pkg::pipe_en_t              en,
  input  logic [opr_pkg::PATTERN_W-1:0]  pattern,
  input  opr_pkg::cnt_t                  orbital_count,
  input  opr_pkg::cnt_t                  set_bit_count,
  output logic [opr_pkg::PATTERN_W-1:0]  bits,
  output opr_pkg::cnt_t                  cnt [opr_pkg::LANES],
  output logic                           ok
);
  import opr_pkg::*;

  localparam cnt_t MAX_N = CNT_W'(MAX_ORBITALS);

  cnt_t                 n_eff;
  logic                 range_ok_nxt, range_ok_r;
  logic [3:0]           byte_cnt_nxt [BYTES];
  logic [3:0]           byte_cnt_r   [BYTES];
  logic [3:0]           in_byte_nxt  [LANES];
  logic [3:0]           in_byte_r    [LANES];
  logic [PATTERN_W-1:0] bits1_r, bits2_r;
  cnt_t                 cnt_nxt [LANES];
  cnt_t                 cnt_r   [LANES];
  logic                 ok_nxt, ok_r;

  always_comb begin
    logic [3:0] acc;
    acc = '0;
    n_eff = (orbital_count > MAX_N) ? MAX_N : orbital_count;
    range_ok_nxt = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (pattern[i] && (CNT_W'(i) >= n_eff)) begin
        range_ok_nxt = 1'b0;
      end
    end
    for (int b = 0; b < BYTES; b++) begin
      acc = '0;
      for (int j = 0; j < 8; j++) begin
        acc = acc + {3'b000, pattern[8*b+j]};
        in_byte_nxt[8*b+j] = acc;
      end
      byte_cnt_nxt[b] = acc;
    end
  end

  always_comb begin
    cnt_t off;
    off = '0;
    for (int b = 0; b < BYTES; b++) begin
      for (int j = 0; j < 8; j++) begin
        cnt_nxt[8*b+j] = off + {3'b000, in_byte_r[8*b+j]};
      end
      off = off + {3'b000, byte_cnt_r[b]};
    end
    ok_nxt = range_ok_r && (off == set_bit_count);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      bits1_r     <= pattern;
      range_ok_r  <= range_ok_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      in_byte_r   <= in_byte_nxt;
    end
    if (en.s2) begin
      bits2_r <= bits1_r;
      cnt_r   <= cnt_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign bits = bits2_r;
  assign cnt  = cnt_r;
  assign ok   = ok_r;

endmodule

### hw/rtl/opr_terms.sv
module opr_terms #(
  parameter int unsigned MAX_ORBITALS = opr_pkg::MAX_ORBITALS_DEF
) (
  input  logic                          clk,
  input  opr_pkg::pipe_en_t             en,
  input  logic [opr_pkg::PATTERN_W-1:0] bits,
  input  opr_pkg::cnt_t                 cnt [opr_pkg::LANES],
  input  logic                          ok_in,
  output opr_pkg::rank_t                terms [opr_pkg::LANES],
  output logic                          ok
);
  import opr_pkg::*;

  rank_t term_nxt [LANES];
  rank_t term_r   [LANES];
  logic  ok_r;

  for (genvar p = 0; p < LANES; p++) begin : g_lane
    if (p < MAX_ORBITALS) begin : g_rom
      localparam binom_row_t ROW = binom_row(p);
      assign term_nxt[p] = bits[p] ? ROW[cnt[p]] : '0;
    end else begin : g_none
      assign term_nxt[p] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      term_r <= term_nxt;
      ok_r   <= ok_in;
    end
  end

  assign terms = term_r;
  assign ok    = ok_r;

endmodule

### hw/rtl/opr_adder.sv
module opr_adder (
  input  logic              clk,
  input  opr_pkg::pipe_en_t en,
  input  opr_pkg::rank_t    terms [opr_pkg::LANES],
  input  logic              ok_in,
  output opr_pkg::rank_t    partial [opr_pkg::LANES/16],
  output logic              ok
);
  import opr_pkg::*;

  localparam int unsigned L1 = LANES / 4;
  localparam int unsigned L2 = LANES / 16;

  rank_t sum1_nxt [L1];
  rank_t sum1_r   [L1];
  rank_t sum2_nxt [L2];
  rank_t sum2_r   [L2];
  logic  ok1_r, ok2_r;

  always_comb begin
    for (int i = 0; i < L1; i++) begin
      sum1_nxt[i] = terms[4*i] + terms[4*i+1] + terms[4*i+2] + terms[4*i+3];
    end
    for (int i = 0; i < L2; i++) begin
      sum2_nxt[i] = sum1_r[4*i] + sum1_r[4*i+1] + sum1_r[4*i+2] + sum1_r[4*i+3];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sum1_r <= sum1_nxt;
      ok1_r  <= ok_in;
    end
    if (en.s5) begin
      sum2_r <= sum2_nxt;
      ok2_r  <= ok1_r;
    end
  end

  assign partial = sum2_r;
  assign ok      = ok2_r;

endmodule
